FILE: rtl/core/bhc_pkg.sv
`default_nettype none

package bhc_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 3;
  localparam int CFG_W  = 3;
  localparam int EC_W   = 3;

  // Counter banks
  localparam int EPOCHS = 2;

  // Edge register file
  localparam int NUM_EDGE_REGS = 7;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_EDGE_COUNT = 3'd0;
  localparam logic [CFG_W-1:0] CFG_EDGE_0     = 3'd1;

  // Edge count limits and reset
  localparam logic [EC_W-1:0] EDGE_COUNT_MIN   = 3'd2;
  localparam logic [EC_W-1:0] EDGE_COUNT_RESET = 3'd2;

  // Counter slots within a bank
  localparam logic [SLOT_W-1:0] SLOT_BELOW = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ABOVE = 3'd1;

  // Item function codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic                     func;
    logic                     epoch_sel;
    logic signed [DATA_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] counter_id;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/binned_histogram_counter.sv
`default_nettype none

// Channel | Direction | Signals                          | Payload
// item    | in        | item_valid, item_ready, item     | func, epoch_sel, sample
// result  | out       | result_valid, result_ready, result | counter_id, count, last
// cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// For a record, one signed comparator walks below, above and the bin edges one
// per cycle, then the counter is read from and written back to the single-port
// counter memory.
// A read returns n+1 results (n = edges in use), each a memory read, then an
// output load; a result stalled at the output holds the next load.
// Synchronous reset clears all counters at once through per-entry valid bits and
// restores the edge registers. Config writes are taken every cycle.

module binned_histogram_counter #(
  parameter int MAX_BINS = 6
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  output logic                             item_ready,
  input  bhc_pkg::item_t                   item,
  output logic                             result_valid,
  input  wire                              result_ready,
  output bhc_pkg::result_t                 result,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [bhc_pkg::CFG_W-1:0]         cfg_index,
  input  wire [bhc_pkg::DATA_W-1:0]        cfg_data
);

  localparam int SLOTS  = MAX_BINS + 2;
  localparam int DEPTH  = bhc_pkg::EPOCHS * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [bhc_pkg::EC_W-1:0] MAX_EDGES = bhc_pkg::EC_W'(MAX_BINS + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LO     = 8'b0000_0010,
    ST_HI     = 8'b0000_0100,
    ST_BIN    = 8'b0000_1000,
    ST_FETCH  = 8'b0001_0000,
    ST_INC    = 8'b0010_0000,
    ST_RFETCH = 8'b0100_0000,
    ST_RLOAD  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers
  logic [bhc_pkg::EC_W-1:0]          edge_count;
  logic signed [bhc_pkg::DATA_W-1:0] edges [bhc_pkg::NUM_EDGE_REGS];

  // Latched transaction
  logic                              epoch;
  logic signed [bhc_pkg::DATA_W-1:0] smp;
  logic [bhc_pkg::SLOT_W-1:0]        slot;

  // Counter memory with per-entry valid bits
  logic [bhc_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld;
  logic [bhc_pkg::CNT_W-1:0] rd_data;
  logic                      rd_hit;
  logic [bhc_pkg::CNT_W-1:0] cnt_val;
  logic [ADDR_W-1:0]         cur_addr;
  logic                      rd_en;
  logic                      wr_en;
  logic [bhc_pkg::CNT_W-1:0] wr_data;

  logic [bhc_pkg::EC_W-1:0]   n_use;
  logic [bhc_pkg::SLOT_W-1:0] sel_idx;
  logic signed [bhc_pkg::DATA_W-1:0] edge_sel;
  logic                       lt;
  logic                       out_free;
  logic                       load;
  logic                       is_last;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);

  // Edges in use, clamped to the supported range
  always_comb begin
    if (edge_count < bhc_pkg::EDGE_COUNT_MIN) begin
      n_use = bhc_pkg::EDGE_COUNT_MIN;
    end else if (edge_count > MAX_EDGES) begin
      n_use = MAX_EDGES;
    end else begin
      n_use = edge_count;
    end
  end

  // Shared comparator: edge operand chosen by the sequencer
  always_comb begin
    priority if (state == ST_HI) begin
      sel_idx = n_use - 3'd1;
    end else if (state == ST_BIN) begin
      sel_idx = slot;
    end else begin
      sel_idx = '0;
    end
  end

  assign edge_sel = edges[sel_idx];
  assign lt       = (smp < edge_sel);

  // Counter address: bank base plus slot
  assign cur_addr = epoch ? (ADDR_W'(SLOTS) + ADDR_W'(slot)) : ADDR_W'(slot);
  assign cnt_val  = rd_hit ? rd_data : '0;

  assign out_free = !result_valid || result_ready;
  assign load     = (state == ST_RLOAD) && out_free;
  assign is_last  = (slot == n_use);

  assign rd_en   = (state == ST_FETCH) || (state == ST_RFETCH);
  assign wr_en   = (state == ST_INC) || load;
  assign wr_data = (state == ST_INC) ? ((cnt_val == '1) ? cnt_val : cnt_val + 1'b1) : '0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= bhc_pkg::EDGE_COUNT_RESET;
      for (int k = 0; k < bhc_pkg::NUM_EDGE_REGS; k++) begin
        edges[k] <= bhc_pkg::DATA_W'(k) << 16;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bhc_pkg::CFG_EDGE_COUNT) begin
        edge_count <= cfg_data[bhc_pkg::EC_W-1:0];
      end else begin
        edges[bhc_pkg::CFG_W'(cfg_index - bhc_pkg::CFG_EDGE_0)] <= cfg_data;
      end
    end
  end

  // Counter memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[cur_addr];
    end
    if (wr_en) begin
      mem[cur_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= vld[cur_addr];
      end
      if (wr_en) begin
        vld[cur_addr] <= 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= '0;
      epoch <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            epoch <= item.epoch_sel;
            slot  <= bhc_pkg::SLOT_BELOW;
            state <= (item.func == bhc_pkg::FUNC_READ) ? ST_RFETCH : ST_LO;
          end
        end
        ST_LO: begin
          if (lt) begin
            slot  <= bhc_pkg::SLOT_BELOW;
            state <= ST_FETCH;
          end else begin
            state <= ST_HI;
          end
        end
        ST_HI: begin
          if (!lt) begin
            slot  <= bhc_pkg::SLOT_ABOVE;
            state <= ST_FETCH;
          end else begin
            slot  <= 3'd1;
            state <= ST_BIN;
          end
        end
        ST_BIN: begin
          // slot holds the upper edge index; bin n sits at slot n+2
          if (lt || slot == n_use - 3'd1) begin
            slot  <= slot + 3'd1;
            state <= ST_FETCH;
          end else begin
            slot <= slot + 3'd1;
          end
        end
        ST_FETCH: begin
          state <= ST_INC;
        end
        ST_INC: begin
          state <= ST_IDLE;
        end
        ST_RFETCH: begin
          state <= ST_RLOAD;
        end
        ST_RLOAD: begin
          if (out_free) begin
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              slot  <= slot + 3'd1;
              state <= ST_RFETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample latch
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      smp <= item.sample;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.counter_id <= slot;
      result.count      <= cnt_val;
      result.last       <= is_last;
    end
  end

  // Checks
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("counter memory read and write in the same cycle");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_RLOAD))
    else $error("result raised outside an output load");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIN) |-> (slot != 3'd0 && slot < n_use))
    else $error("bin edge index out of range");

  a_last_ends_read: assert property (@(posedge clk) disable iff (rst)
    (load && is_last) |=> (state == ST_IDLE))
    else $error("read did not finish after its last result");

endmodule

`default_nettype wire
